// ----- rtl/u8u16_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and the byte classifier for the transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] QMARK      = 16'h003F;
  localparam logic [15:0] SURR_HIGH  = 16'hD800;
  localparam logic [15:0] SURR_LOW   = 16'hDC00;
  localparam logic [20:0] PLANE_ONE  = 21'h10000;

  typedef enum logic [2:0] {
    CLS_CONT  = 3'd0,
    CLS_ASCII = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_LEAD4 = 3'd4,
    CLS_BAD   = 3'd5
  } class_t;

  // One queued job: a run of '?' units, then optionally one code point.
  typedef struct packed {
    logic [2:0]  qcount;
    logic        has_tail;
    logic [20:0] cp;
    logic        last;
  } job_t;

  function automatic class_t classify_byte(input logic [7:0] b);
    class_t c;
    case (b[7:3]) inside
      [5'd0:5'd15]:  c = CLS_ASCII;
      [5'd16:5'd23]: c = CLS_CONT;
      [5'd24:5'd27]: c = CLS_LEAD2;
      [5'd28:5'd29]: c = CLS_LEAD3;
      5'd30:         c = CLS_LEAD4;
      default:       c = CLS_BAD;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/utf8_to_utf16_transcoder.sv -----
`timescale 1ns / 1ps
// A byte's job is registered in the job queue; its units pass the output register.
// Throughput: one byte per cycle in, one unit per cycle out while out_ready is high;
// error bursts that give several '?' units per byte fill the queue, then stall input.
// Reset clears the open sequence, the job queue and the output valid.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream to UTF-16 code units, with '?' for malformed bytes.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] unit_value,
  output logic        last_unit
);

  logic            push;
  u8u16_pkg::job_t push_job;
  logic            pop;
  u8u16_pkg::job_t head;
  logic            empty;
  logic            full;

  u8u16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .full       (full),
    .push       (push),
    .push_job   (push_job)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .unit_value (unit_value),
    .last_unit  (last_unit)
  );

endmodule

// ----- rtl/u8u16_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts bytes, tracks the open sequence and queues one job per byte that
// produces output.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         byte_value,
  input  logic               last_byte,
  input  logic               full,
  output logic               push,
  output u8u16_pkg::job_t    push_job
);

  logic [7:0]        held [3];
  logic [1:0]        held_count;
  logic [1:0]        held_count_next;
  logic [2:0]        needed_count;
  logic [2:0]        needed_count_next;
  u8u16_pkg::class_t cls;
  u8u16_pkg::job_t   job;
  logic              fresh;
  logic              wr_en;
  logic              open_new;
  logic              accept;
  logic [20:0]       cp_full;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign cls      = u8u16_pkg::classify_byte(byte_value);

  always_comb begin
    case (needed_count)
      3'd3:    cp_full = {5'd0, held[0][3:0], held[1][5:0], byte_value[5:0]};
      3'd4:    cp_full = {held[0][2:0], held[1][5:0], held[2][5:0], byte_value[5:0]};
      default: cp_full = {10'd0, held[0][4:0], byte_value[5:0]};
    endcase
  end

  always_comb begin
    job               = '0;
    job.last          = last_byte;
    fresh             = 1'b1;
    wr_en             = 1'b0;
    open_new          = 1'b0;
    held_count_next   = held_count;
    needed_count_next = needed_count;
    if (needed_count != 3'd0) begin
      if (cls == u8u16_pkg::CLS_CONT) begin
        fresh = 1'b0;
        if (({1'b0, held_count} + 3'd1) >= needed_count) begin
          job.has_tail      = 1'b1;
          job.cp            = cp_full;
          held_count_next   = 2'd0;
          needed_count_next = 3'd0;
        end else begin
          wr_en = 1'b1;
          if (last_byte) begin
            job.qcount        = {1'b0, held_count} + 3'd1;
            held_count_next   = 2'd0;
            needed_count_next = 3'd0;
          end else begin
            held_count_next = held_count + 2'd1;
          end
        end
      end else begin
        job.qcount        = {1'b0, held_count};
        held_count_next   = 2'd0;
        needed_count_next = 3'd0;
      end
    end
    if (fresh) begin
      case (cls)
        u8u16_pkg::CLS_ASCII: begin
          job.has_tail = 1'b1;
          job.cp       = {13'd0, byte_value};
        end
        u8u16_pkg::CLS_CONT, u8u16_pkg::CLS_BAD: begin
          job.qcount = job.qcount + 3'd1;
        end
        default: begin
          if (last_byte) begin
            job.qcount = job.qcount + 3'd1;
          end else begin
            open_new          = 1'b1;
            held_count_next   = 2'd1;
            needed_count_next = cls;
          end
        end
      endcase
    end
  end

  assign push     = accept && (job.qcount != 3'd0 || job.has_tail);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      needed_count <= 3'd0;
    end else if (accept) begin
      held_count   <= held_count_next;
      needed_count <= needed_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if ((wr_en && held_count == 2'(i)) || (open_new && i == 0)) begin
          held[i] <= byte_value;
        end
      end
    end
  end

endmodule

// ----- rtl/u8u16_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_queue
// Short job queue between the byte front end and the unit back end.
// ----------------------------------------------------------------------------
module u8u16_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8u16_pkg::job_t push_job,
  input  logic            pop,
  output u8u16_pkg::job_t head,
  output logic            empty,
  output logic            full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8u16_pkg::job_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == CW'(0));
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- rtl/u8u16_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_back
// Expands queued jobs into UTF-16 units, one per cycle while the receiver takes
// them, into the output register.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic            clk,
  input  logic            rst,
  input  u8u16_pkg::job_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     unit_value,
  output logic            last_unit
);

  logic [2:0]  idx;
  logic        pair;
  logic [2:0]  total;
  logic        final_unit;
  logic        load;
  logic [20:0] v;
  logic [15:0] unit;

  assign pair       = head.has_tail && (head.cp[20:16] != 5'd0);
  assign total      = head.qcount + {2'd0, head.has_tail} + {2'd0, pair};
  assign final_unit = (idx == total - 3'd1);
  assign load       = !empty && (!out_valid || out_ready);
  assign pop        = load && final_unit;
  assign v          = head.cp - u8u16_pkg::PLANE_ONE;

  always_comb begin
    if (idx < head.qcount) begin
      unit = u8u16_pkg::QMARK;
    end else if (!pair) begin
      unit = head.cp[15:0];
    end else if (idx == head.qcount) begin
      unit = u8u16_pkg::SURR_HIGH + {5'd0, v[20:10]};
    end else begin
      unit = u8u16_pkg::SURR_LOW | {6'd0, v[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= final_unit ? 3'd0 : idx + 3'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_value <= unit;
      last_unit  <= head.last && final_unit;
    end
  end

endmodule

// ----- test/tb_utf8_to_utf16_transcoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder
// Drives UTF-8 byte streams into the transcoder and predicts every UTF-16
// unit in the testbench. Results are compared in order, field by field.
// The stimulus is a directed set of well-formed, overlong, surrogate,
// broken and truncated sequences, then a burst of errors against a stalled
// receiver. After that come random streams that are mostly well-formed
// sequences, mixed with broken sequences and noise bytes. Sender gaps and
// receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder;

  class unit_tracker;
    typedef struct {
      logic [15:0] value;
      logic        last;
    } unit_t;

    unit_t      units_due[$];
    unit_t      step_units[$];
    logic [7:0] held[3];
    logic [1:0] held_cnt;
    logic [2:0] need_cnt;
    int         mismatches;

    function new();
      held_cnt   = 2'd0;
      need_cnt   = 3'd0;
      mismatches = 0;
    endfunction

    function void push_unit(logic [15:0] u);
      unit_t e;
      e.value = u;
      e.last  = 1'b0;
      if (step_units.size() < 4) step_units.push_back(e);
    endfunction

    function void flush_held();
      int i;
      for (i = 0; i < held_cnt; i++) push_unit(u8u16_pkg::QMARK);
      held_cnt = 2'd0;
      need_cnt = 3'd0;
    endfunction

    function void take_byte(logic [7:0] b, logic lb);
      u8u16_pkg::class_t cls;
      bit                fresh;
      int                len;
      int                i;
      logic [20:0]       cp;
      logic [20:0]       v;
      if (b < 8'h80) cls = u8u16_pkg::CLS_ASCII;
      else if (b < 8'hC0) cls = u8u16_pkg::CLS_CONT;
      else if (b < 8'hE0) cls = u8u16_pkg::CLS_LEAD2;
      else if (b < 8'hF0) cls = u8u16_pkg::CLS_LEAD3;
      else if (b < 8'hF8) cls = u8u16_pkg::CLS_LEAD4;
      else cls = u8u16_pkg::CLS_BAD;
      fresh = 1'b1;
      step_units.delete();
      if (need_cnt != 3'd0) begin
        if (cls == u8u16_pkg::CLS_CONT) begin
          fresh = 1'b0;
          if (held_cnt + 1 >= need_cnt) begin
            len = int'(need_cnt);
            cp  = 21'(held[0] & (8'hFF >> (len + 1)));
            for (i = 1; i < held_cnt && i < 3; i++) cp = (cp << 6) | 21'(held[i] & 8'h3F);
            cp = (cp << 6) | 21'(b & 8'h3F);
            held_cnt = 2'd0;
            need_cnt = 3'd0;
            if (cp < u8u16_pkg::PLANE_ONE) begin
              push_unit(cp[15:0]);
            end else begin
              v = cp - u8u16_pkg::PLANE_ONE;
              push_unit(u8u16_pkg::SURR_HIGH + 16'(v >> 10));
              push_unit(u8u16_pkg::SURR_LOW + 16'(v & 21'h3FF));
            end
          end else begin
            held[held_cnt] = b;
            held_cnt = held_cnt + 2'd1;
            if (lb) flush_held();
          end
        end else begin
          flush_held();
        end
      end
      if (fresh) begin
        if (cls == u8u16_pkg::CLS_ASCII) begin
          push_unit({8'h00, b});
        end else if (cls == u8u16_pkg::CLS_CONT || cls == u8u16_pkg::CLS_BAD) begin
          push_unit(u8u16_pkg::QMARK);
        end else if (lb) begin
          push_unit(u8u16_pkg::QMARK);
        end else begin
          held[0]  = b;
          held_cnt = 2'd1;
          need_cnt = (cls == u8u16_pkg::CLS_LEAD2) ? 3'd2 :
                     (cls == u8u16_pkg::CLS_LEAD3) ? 3'd3 : 3'd4;
        end
      end
      if (lb && step_units.size() > 0) step_units[step_units.size() - 1].last = 1'b1;
      foreach (step_units[i]) units_due.push_back(step_units[i]);
    endfunction

    function void match_unit(logic [15:0] u, logic l);
      unit_t e;
      if (units_due.size() == 0) begin
        $display("%0t: unexpected word, unit_value %h last_unit %b", $time, u, l);
        mismatches++;
        return;
      end
      e = units_due.pop_front();
      if (u !== e.value) begin
        $display("%0t: unit_value expected %h actual %h", $time, e.value, u);
        mismatches++;
      end
      if (l !== e.last) begin
        $display("%0t: last_unit expected %b actual %b", $time, e.last, l);
        mismatches++;
      end
    endfunction

    function int units_waiting();
      return units_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_value;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] unit_value;
  logic        last_unit;

  unit_tracker tracker = new();
  int          burst_left;
  int          gap_max;
  int          bytes_sent;
  int          hold_reqs;

  utf8_to_utf16_transcoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .unit_value (unit_value),
    .last_unit  (last_unit)
  );

  always #10 clk = ~clk;

  task automatic send_byte(input logic [7:0] b, input logic lb);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(12, 1);
    end
    burst_left--;
    in_valid   <= 1'b1;
    byte_value <= b;
    last_byte  <= lb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_byte(b, lb);
    bytes_sent++;
  endtask

  // hold input until every predicted word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.units_waiting() != 0) @(posedge clk);
  endtask

  task automatic send_sequence(input int len, input int conts, input logic lb);
    logic [7:0] lead;
    int         i;
    case (len)
      1:       lead = 8'($urandom_range(127));
      2:       lead = 8'hC0 | 8'($urandom_range(31));
      3:       lead = 8'hE0 | 8'($urandom_range(15));
      default: lead = 8'hF0 | 8'($urandom_range(7));
    endcase
    send_byte(lead, lb && conts == 0);
    for (i = 1; i <= conts; i++) send_byte(8'h80 | 8'($urandom_range(63)), lb && i == conts);
  endtask

  task automatic random_stream(input int count);
    int         target;
    int         kind;
    int         len;
    int         k;
    logic [7:0] b;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        len = $urandom_range(4, 1);
        send_sequence(len, len - 1, $urandom_range(7) == 0);
      end else if (kind < 78) begin
        len = $urandom_range(4, 2);
        k   = $urandom_range(len - 2);
        if ($urandom_range(1)) begin
          send_sequence(len, k, 1'b1);
        end else begin
          send_sequence(len, k, 1'b0);
          b = 8'($urandom);
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          send_byte(b, $urandom_range(3) == 0);
        end
      end else begin
        send_byte(8'($urandom), $urandom_range(15) == 0);
      end
    end
  endtask

  initial begin
    logic [7:0] pattern;
    int         hold_left;
    int         holds_served;
    int         cyc;
    pattern      = 8'hFF;
    hold_left    = 0;
    holds_served = 0;
    cyc          = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) tracker.match_unit(unit_value, last_unit);
      if (holds_served != hold_reqs) begin
        holds_served++;
        hold_left = 80;
      end
      if (cyc % 48 == 0) begin
        pattern = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
        if (pattern == 8'h00) pattern = 8'h01;
      end
      cyc++;
      pattern = {pattern[0], pattern[7:1]};
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= pattern[0];
      end
    end
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    byte_value <= 8'h00;
    last_byte  <= 1'b0;
    hold_reqs  <= 0;
    burst_left = 0;
    gap_max    = 0;
    bytes_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hC3, 1'b1);

    // stall the receiver and keep feeding error bursts
    hold_reqs <= hold_reqs + 1;
    repeat (8) begin
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'hF8, 1'b0);
    end
    wait_drained();

    random_stream(40);
    gap_max = 4;
    random_stream(60);
    hold_reqs <= hold_reqs + 1;
    gap_max = 10;
    random_stream(60);

    wait_drained();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.units_waiting() == 0) begin
      $display("tb_utf8_to_utf16_transcoder passed");
    end else begin
      $display("tb_utf8_to_utf16_transcoder failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_utf8_to_utf16_transcoder failed");
    $finish;
  end

endmodule
